// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on aclk, off while in reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off while in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/swa_pkg.sv -----
// Shared constants, types and helper functions of the sliding window block.
package swa_pkg;

    localparam int MAX_DEPTH = 64;
    localparam int SLOT_W    = $clog2(MAX_DEPTH);
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
    localparam int SAMPLE_W  = 16;
    localparam int STAMP_W   = 32;
    localparam int TOTAL_W   = 22;
    localparam int SUM_W     = TOTAL_W + 2;
    localparam int DIV_STEPS = TOTAL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
    localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

    localparam logic [DEPTH_W-1:0] DEPTH_RESET  = DEPTH_W'(MAX_DEPTH);
    localparam logic [STAMP_W-1:0] WINDOW_RESET = STAMP_W'(60 * 1000);

    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_DEPTH  = 2'd1,
        REG_WINDOW = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_UPDATE,
        ST_DIV,
        ST_STORE,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                mode;
        logic [DEPTH_W-1:0]  active_depth;
        logic [STAMP_W-1:0]  window_ms;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic div_step;
        logic store;
        logic walk;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic item_mode;
        logic div_last;
        logic walk_last;
        logic out_free;
    } status_t;

    function automatic logic [DEPTH_W-1:0] depth_clamp(input logic [DEPTH_W-1:0] d);
        if (d == '0) begin
            return DEPTH_W'(1);
        end
        if (d > DEPTH_W'(MAX_DEPTH)) begin
            return DEPTH_W'(MAX_DEPTH);
        end
        return d;
    endfunction

    function automatic logic signed [TOTAL_W-1:0] sat_total(input logic signed [SUM_W-1:0] x);
        if (x > SUM_W'(TOTAL_MAX)) begin
            return TOTAL_MAX;
        end
        if (x < SUM_W'(TOTAL_MIN)) begin
            return TOTAL_MIN;
        end
        return x[TOTAL_W-1:0];
    endfunction

endpackage

// ----- rtl/swa_regs.sv -----
// APB register file: mode, active depth and window length.
module swa_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [swa_pkg::PADDR_W-1:0]  paddr,
    input  logic [swa_pkg::PDATA_W-1:0]  pwdata,
    output logic [swa_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output swa_pkg::cfg_t                cfg
);
    import swa_pkg::*;

    logic               mode_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [STAMP_W-1:0] window_reg;
    logic               wr_en;
    reg_index_t         index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = reg_index_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b0;
            depth_reg  <= DEPTH_RESET;
            window_reg <= WINDOW_RESET;
        end else if (wr_en) begin
            unique case (index)
                REG_MODE:   mode_reg   <= pwdata[0];
                REG_DEPTH:  depth_reg  <= pwdata[DEPTH_W-1:0];
                REG_WINDOW: window_reg <= pwdata[STAMP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (index)
            REG_MODE:   prdata = PDATA_W'(mode_reg);
            REG_DEPTH:  prdata = PDATA_W'(depth_reg);
            REG_WINDOW: prdata = PDATA_W'(window_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.mode         = mode_reg;
    assign cfg.active_depth = depth_reg;
    assign cfg.window_ms    = window_reg;

endmodule

// ----- rtl/swa_dp.sv -----
// Datapath: sample and stamp rings, running total, divider, window walk, result register.
module swa_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  swa_pkg::cfg_t                       cfg,
    input  swa_pkg::cmd_t                       cmd,
    output swa_pkg::status_t                    status,
    input  logic signed [swa_pkg::SAMPLE_W-1:0] s_sample_value,
    input  logic        [swa_pkg::STAMP_W-1:0]  s_time_ms,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [swa_pkg::SAMPLE_W-1:0] m_average,
    output logic signed [swa_pkg::SAMPLE_W-1:0] m_peak_value,
    output logic signed [swa_pkg::TOTAL_W-1:0]  m_window_sum,
    output logic        [swa_pkg::DEPTH_W-1:0]  m_window_count
);
    import swa_pkg::*;

    localparam logic [TOTAL_W-1:0] AVG_POS_LIM = TOTAL_W'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic [TOTAL_W-1:0] AVG_NEG_LIM = TOTAL_W'(2 ** (SAMPLE_W - 1));

    logic signed [SAMPLE_W-1:0] sample_mem [MAX_DEPTH];
    logic        [STAMP_W-1:0]  stamp_mem  [MAX_DEPTH];

    // state with defined reset
    logic [MAX_DEPTH-1:0]       sample_valid_reg, sample_valid_next;
    logic [MAX_DEPTH-1:0]       written_reg, written_next;
    logic [SLOT_W-1:0]          write_slot_reg, write_slot_next;
    logic signed [TOTAL_W-1:0]  running_total_reg, running_total_next;
    logic signed [SAMPLE_W-1:0] highest_reg, highest_next;
    logic                       m_valid_reg, m_valid_next;
    logic                       acc_pend_reg;

    // per-item working registers
    logic signed [SAMPLE_W-1:0] item_sample_reg;
    logic [STAMP_W-1:0]         item_time_reg;
    logic                       item_mode_reg;
    logic [DEPTH_W-1:0]         depth_reg;
    logic [SLOT_W-1:0]          slot_reg;
    logic signed [SAMPLE_W-1:0] rd_sample_reg;
    logic [STAMP_W-1:0]         rd_stamp_reg;
    logic                       rd_svalid_reg;
    logic                       rd_written_reg;
    logic [SLOT_W-1:0]          walk_idx_reg;
    logic signed [SUM_W-1:0]    acc_reg;
    logic [DEPTH_W-1:0]         count_reg;
    logic [TOTAL_W-1:0]         num_reg;
    logic [DEPTH_W-1:0]         rem_reg;
    logic                       neg_reg;
    logic [DIV_CNT_W-1:0]       div_cnt_reg;

    logic signed [SAMPLE_W-1:0] avg_reg;
    logic signed [SAMPLE_W-1:0] peak_reg;
    logic signed [TOTAL_W-1:0]  wsum_reg;
    logic [DEPTH_W-1:0]         wcount_reg;

    logic [DEPTH_W-1:0]         cur_depth;
    logic [SLOT_W-1:0]          cur_slot;
    logic [SLOT_W-1:0]          rd_addr;
    logic signed [SAMPLE_W-1:0] old_sample;
    logic signed [SUM_W-1:0]    tot_wide;
    logic signed [TOTAL_W-1:0]  tot_sat;
    logic signed [SUM_W-1:0]    tot_mag;
    logic [DEPTH_W:0]           trial;
    logic                       qbit;
    logic [STAMP_W-1:0]         age;
    logic                       hit;
    logic signed [TOTAL_W-1:0]  wsum_sat;
    logic signed [SAMPLE_W-1:0] avg_sat;
    logic [TOTAL_W-1:0]         q_neg;
    logic [DEPTH_W-1:0]         slot_inc;

    assign cur_depth = depth_clamp(cfg.active_depth);
    assign cur_slot  = (DEPTH_W'(write_slot_reg) < cur_depth) ? write_slot_reg : '0;
    assign rd_addr   = cmd.walk ? walk_idx_reg : slot_reg;

    // ring memories, registered read
    always_ff @(posedge aclk) begin
        if (cmd.update || cmd.store) begin
            sample_mem[slot_reg] <= item_sample_reg;
        end
        if (cmd.store) begin
            stamp_mem[slot_reg] <= item_time_reg;
        end
        rd_sample_reg  <= sample_mem[rd_addr];
        rd_stamp_reg   <= stamp_mem[rd_addr];
        rd_svalid_reg  <= sample_valid_reg[rd_addr];
        rd_written_reg <= written_reg[rd_addr];
    end

    // running total update and divider
    assign old_sample = rd_svalid_reg ? rd_sample_reg : '0;
    assign tot_wide   = SUM_W'(running_total_reg) - SUM_W'(old_sample)
                        + SUM_W'(item_sample_reg);
    assign tot_sat    = sat_total(tot_wide);
    assign tot_mag    = tot_sat[TOTAL_W-1] ? -SUM_W'(tot_sat) : SUM_W'(tot_sat);
    assign trial      = {rem_reg, num_reg[TOTAL_W-1]};
    assign qbit       = trial >= {1'b0, depth_reg};

    // window walk
    assign age = item_time_reg - rd_stamp_reg;
    assign hit = rd_written_reg && (age < cfg.window_ms);

    assign wsum_sat = sat_total(acc_reg);
    assign q_neg    = -num_reg;

    always_comb begin
        if (!neg_reg) begin
            avg_sat = (num_reg > AVG_POS_LIM) ? SAMPLE_W'(AVG_POS_LIM) : num_reg[SAMPLE_W-1:0];
        end else begin
            avg_sat = (num_reg > AVG_NEG_LIM) ? SAMPLE_W'(AVG_NEG_LIM) : q_neg[SAMPLE_W-1:0];
        end
    end

    assign slot_inc = DEPTH_W'(slot_reg) + DEPTH_W'(1);

    always_comb begin
        sample_valid_next  = sample_valid_reg;
        written_next       = written_reg;
        write_slot_next    = write_slot_reg;
        running_total_next = running_total_reg;
        highest_next       = highest_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        if (cmd.update || cmd.store) begin
            sample_valid_next[slot_reg] = 1'b1;
        end
        if (cmd.store) begin
            written_next[slot_reg] = 1'b1;
        end
        if (cmd.update) begin
            running_total_next = tot_sat;
            if (item_sample_reg > highest_reg) begin
                highest_next = item_sample_reg;
            end
        end
        if (cmd.finish) begin
            m_valid_next    = 1'b1;
            write_slot_next = (slot_inc >= depth_reg) ? '0 : slot_inc[SLOT_W-1:0];
            if (item_mode_reg) begin
                running_total_next = wsum_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_valid_reg  <= '0;
            written_reg       <= '0;
            write_slot_reg    <= '0;
            running_total_reg <= '0;
            highest_reg       <= '0;
            m_valid_reg       <= 1'b0;
            acc_pend_reg      <= 1'b0;
        end else begin
            sample_valid_reg  <= sample_valid_next;
            written_reg       <= written_next;
            write_slot_reg    <= write_slot_next;
            running_total_reg <= running_total_next;
            highest_reg       <= highest_next;
            m_valid_reg       <= m_valid_next;
            acc_pend_reg      <= cmd.walk;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_sample_reg <= s_sample_value;
            item_time_reg   <= s_time_ms;
            item_mode_reg   <= cfg.mode;
            depth_reg       <= cur_depth;
            slot_reg        <= cur_slot;
        end
        if (cmd.update) begin
            neg_reg     <= tot_sat[TOTAL_W-1];
            num_reg     <= tot_mag[TOTAL_W-1:0];
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            num_reg     <= {num_reg[TOTAL_W-2:0], qbit};
            rem_reg     <= qbit ? DEPTH_W'(trial - {1'b0, depth_reg}) : trial[DEPTH_W-1:0];
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.store) begin
            walk_idx_reg <= '0;
            acc_reg      <= '0;
            count_reg    <= '0;
        end
        if (cmd.walk) begin
            walk_idx_reg <= walk_idx_reg + SLOT_W'(1);
        end
        if (acc_pend_reg && hit) begin
            acc_reg   <= acc_reg + SUM_W'(rd_sample_reg);
            count_reg <= count_reg + DEPTH_W'(1);
        end
        if (cmd.finish) begin
            avg_reg    <= item_mode_reg ? '0 : avg_sat;
            peak_reg   <= item_mode_reg ? '0 : highest_reg;
            wsum_reg   <= item_mode_reg ? wsum_sat : '0;
            wcount_reg <= item_mode_reg ? count_reg : '0;
        end
    end

    assign status.item_mode = item_mode_reg;
    assign status.div_last  = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign status.walk_last = (DEPTH_W'(walk_idx_reg) + DEPTH_W'(1) == depth_reg);
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_average      = avg_reg;
    assign m_peak_value   = peak_reg;
    assign m_window_sum   = wsum_reg;
    assign m_window_count = wcount_reg;

endmodule

// ----- rtl/swa_ctrl.sv -----
// Controller: sequences capture, total update and divide, or ring store and walk.
module swa_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  swa_pkg::status_t status,
    output swa_pkg::cmd_t    cmd
);
    import swa_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:  state_next = status.item_mode ? ST_STORE : ST_UPDATE;
            ST_UPDATE: state_next = ST_DIV;
            ST_DIV: begin
                if (status.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_STORE:  state_next = ST_WALK;
            ST_WALK: begin
                if (status.walk_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_DONE;
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_UPDATE: cmd.update   = 1'b1;
            ST_DIV:    cmd.div_step = 1'b1;
            ST_STORE:  cmd.store    = 1'b1;
            ST_WALK:   cmd.walk     = 1'b1;
            ST_DONE:   cmd.finish   = status.out_free;
            default: begin
            end
        endcase
    end

endmodule

// ----- rtl/sliding_window_average_and_sum_core.sv -----
// Top level of the sliding window average and time window sum block.
//
//   channel   dir  handshake        beat contents
//   s_        in   s_valid/s_ready  sample_value, time_ms
//   m_        out  m_valid/m_ready  average, peak_value, window_sum, window_count
//   apb       in   psel/penable     mode, active_depth, window_ms
//
// Mode 0: fetch, update, 22-step restoring divide, done.
// Mode 1: fetch, store, ring walk, drain, done; one ring entry read per cycle.
// Reset clears the state registers, not the ring memories; ring entries carry valid bits.
// A finished result waits in the output register; the next beat is taken meanwhile,
// and only the done step stalls while that register is still full.
`include "assert_macros.svh"

module sliding_window_average_and_sum_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swa_pkg::PADDR_W-1:0]         paddr,
    input  logic [swa_pkg::PDATA_W-1:0]         pwdata,
    output logic [swa_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [swa_pkg::SAMPLE_W-1:0] s_sample_value,
    input  logic        [swa_pkg::STAMP_W-1:0]  s_time_ms,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [swa_pkg::SAMPLE_W-1:0] m_average,
    output logic signed [swa_pkg::SAMPLE_W-1:0] m_peak_value,
    output logic signed [swa_pkg::TOTAL_W-1:0]  m_window_sum,
    output logic        [swa_pkg::DEPTH_W-1:0]  m_window_count
);
    import swa_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    swa_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    swa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    swa_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .cmd            (cmd),
        .status         (status),
        .s_sample_value (s_sample_value),
        .s_time_ms      (s_time_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_average      (m_average),
        .m_peak_value   (m_peak_value),
        .m_window_sum   (m_window_sum),
        .m_window_count (m_window_count)
    );

    `ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready high after accept")
    `ASSERT_NEXT(a_finish_loads_out, cmd.finish, m_valid, "result lost at finish")
    `ASSERT_IMPLIES(a_unused_fields_zero, m_valid,
        (m_window_count == '0 && m_window_sum == '0) || (m_average == '0 && m_peak_value == '0),
        "fields of the other mode not zero")
    `ASSERT_IMPLIES(a_count_bound, m_valid, m_window_count <= DEPTH_W'(MAX_DEPTH),
        "window count above ring depth")

endmodule

// ----- dv/sliding_window_average_and_sum_core_checker.sv -----
// Watches the sample, result and register ports, predicts each result beat and compares it.
module sliding_window_average_and_sum_core_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swa_pkg::PADDR_W-1:0]         paddr,
    input  logic [swa_pkg::PDATA_W-1:0]         pwdata,
    input  logic                                pready,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic signed [swa_pkg::SAMPLE_W-1:0] s_sample_value,
    input  logic [swa_pkg::STAMP_W-1:0]         s_time_ms,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [swa_pkg::SAMPLE_W-1:0] m_average,
    input  logic signed [swa_pkg::SAMPLE_W-1:0] m_peak_value,
    input  logic signed [swa_pkg::TOTAL_W-1:0]  m_window_sum,
    input  logic [swa_pkg::DEPTH_W-1:0]         m_window_count,
    output int                                  mismatches,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import swa_pkg::*;

    localparam longint TOTAL_HI = (longint'(1) <<< (TOTAL_W - 1)) - 1;
    localparam longint TOTAL_LO = -(longint'(1) <<< (TOTAL_W - 1));
    localparam int     AVG_HI   = 32767;
    localparam int     AVG_LO   = -32768;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
        logic signed [SAMPLE_W-1:0] peak_value;
        logic signed [TOTAL_W-1:0]  window_sum;
        logic [DEPTH_W-1:0]         window_count;
    } window_result_t;

    logic                       window_mode;
    logic [DEPTH_W-1:0]         depth_reg;
    logic [STAMP_W-1:0]         window_reg;
    logic signed [SAMPLE_W-1:0] ring_sample [MAX_DEPTH];
    logic [STAMP_W-1:0]         ring_stamp [MAX_DEPTH];
    logic                       ring_written [MAX_DEPTH];
    int                         wr_pos;
    logic signed [TOTAL_W-1:0]  run_total;
    logic signed [SAMPLE_W-1:0] top_sample;
    window_result_t             queued_window_results [$];

    function automatic logic signed [TOTAL_W-1:0] clip_total(input longint x);
        if (x > TOTAL_HI) begin
            return TOTAL_W'(TOTAL_HI);
        end
        if (x < TOTAL_LO) begin
            return TOTAL_W'(TOTAL_LO);
        end
        return TOTAL_W'(x);
    endfunction

    task automatic update_ring_and_predict(
        input  logic signed [SAMPLE_W-1:0] v,
        input  logic [STAMP_W-1:0]         t,
        output window_result_t             r
    );
        int                 d;
        int                 pos;
        int                 quo;
        int                 cnt;
        longint             acc;
        logic [STAMP_W-1:0] age;
        d = int'(depth_reg);
        if (d == 0) begin
            d = 1;
        end
        if (d > MAX_DEPTH) begin
            d = MAX_DEPTH;
        end
        pos = (wr_pos < d) ? wr_pos : 0;
        r = '0;
        if (!window_mode) begin
            acc = longint'(run_total) - longint'(ring_sample[pos]) + longint'(v);
            run_total = clip_total(acc);
            ring_sample[pos] = v;
            quo = int'(run_total) / d;
            if (quo > AVG_HI) begin
                quo = AVG_HI;
            end
            if (quo < AVG_LO) begin
                quo = AVG_LO;
            end
            r.average = SAMPLE_W'(quo);
            if (v > top_sample) begin
                top_sample = v;
            end
            r.peak_value = top_sample;
        end else begin
            ring_sample[pos] = v;
            ring_stamp[pos] = t;
            ring_written[pos] = 1'b1;
            acc = 0;
            cnt = 0;
            for (int i = 0; i < d; i++) begin
                age = t - ring_stamp[i];
                if (ring_written[i] && age < window_reg) begin
                    acc += longint'(ring_sample[i]);
                    cnt++;
                end
            end
            run_total = clip_total(acc);
            r.window_sum = run_total;
            r.window_count = DEPTH_W'(cnt);
        end
        pos++;
        if (pos >= d) begin
            pos = 0;
        end
        wr_pos = pos;
    endtask

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        window_result_t want;
        if (!aresetn) begin
            window_mode = 1'b0;
            depth_reg = DEPTH_RESET;
            window_reg = WINDOW_RESET;
            for (int i = 0; i < MAX_DEPTH; i++) begin
                ring_sample[i] = '0;
                ring_stamp[i] = '0;
                ring_written[i] = 1'b0;
            end
            wr_pos = 0;
            run_total = '0;
            top_sample = '0;
            queued_window_results.delete();
            pending = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_index_t'(paddr[PADDR_W-1:2]))
                    REG_MODE: window_mode = pwdata[0];
                    REG_DEPTH: depth_reg = pwdata[DEPTH_W-1:0];
                    REG_WINDOW: window_reg = pwdata[STAMP_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (queued_window_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat, expected none, actual %0d %0d %0d %0d",
                             $time, m_average, m_peak_value, m_window_sum, m_window_count);
                end else begin
                    want = queued_window_results.pop_front();
                    check_field("average", want.average, m_average);
                    check_field("peak_value", want.peak_value, m_peak_value);
                    check_field("window_sum", want.window_sum, m_window_sum);
                    check_field("window_count", want.window_count, m_window_count);
                end
            end
            if (s_valid && s_ready) begin
                update_ring_and_predict(s_sample_value, s_time_ms, want);
                queued_window_results.push_back(want);
            end
            pending = queued_window_results.size();
        end
    end

endmodule

// ----- dv/sliding_window_average_and_sum_core_tb.sv -----
// Stimulus, clock, reset and verdict for the sliding window average and sum core.
module sliding_window_average_and_sum_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swa_pkg::*;

    localparam int   CYCLE_LIMIT   = 1_000_000;
    localparam int   HOLD_CYCLES   = 400;
    localparam int   TAIL_CYCLES   = 100;
    localparam int   RANDOM_BLOCKS = 23;
    localparam int   BLOCK_BEATS   = 30;
    localparam int   RAIL_BEATS    = 40;
    localparam logic MODE_AVERAGE  = 1'b0;
    localparam logic MODE_WINDOW   = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_HI = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_LO = 16'sh8000;

    logic                       aclk           = 1'b0;
    logic                       aresetn        = 1'b0;
    logic                       psel           = 1'b0;
    logic                       penable        = 1'b0;
    logic                       pwrite         = 1'b0;
    logic [PADDR_W-1:0]         paddr          = '0;
    logic [PDATA_W-1:0]         pwdata         = '0;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;
    logic                       s_valid        = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_value = '0;
    logic [STAMP_W-1:0]         s_time_ms      = '0;
    logic                       m_valid;
    logic                       m_ready        = 1'b0;
    logic signed [SAMPLE_W-1:0] m_average;
    logic signed [SAMPLE_W-1:0] m_peak_value;
    logic signed [TOTAL_W-1:0]  m_window_sum;
    logic [DEPTH_W-1:0]         m_window_count;

    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    logic               hold_req       = 1'b0;
    logic               hold_done      = 1'b0;
    int                 hold_left      = 0;
    int                 cycles         = 0;
    int                 mismatches;
    int                 pending;
    logic [STAMP_W-1:0] now_ms         = '0;

    always #1 aclk = ~aclk;

    sliding_window_average_and_sum_core i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_value (s_sample_value),
        .s_time_ms      (s_time_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_average      (m_average),
        .m_peak_value   (m_peak_value),
        .m_window_sum   (m_window_sum),
        .m_window_count (m_window_count)
    );

    sliding_window_average_and_sum_core_checker i_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_value (s_sample_value),
        .s_time_ms      (s_time_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_average      (m_average),
        .m_peak_value   (m_peak_value),
        .m_window_sum   (m_window_sum),
        .m_window_count (m_window_count),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    // result sink: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("sliding_window_average_and_sum_core verification failed");
        $finish;
    end

    task automatic write_reg(input reg_index_t idx, input logic [PDATA_W-1:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_beat(input logic signed [SAMPLE_W-1:0] v, input logic [STAMP_W-1:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample_value <= v;
        s_time_ms <= t;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return SAMPLE_HI;
            1: return SAMPLE_LO;
            2, 3: return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // fill the ring against the rail, reseed the total from one young beat, then push it over
    task automatic drive_total_to_rail(input logic upward);
        int k;
        settle();
        write_reg(REG_MODE, PDATA_W'(MODE_AVERAGE));
        write_reg(REG_DEPTH, PDATA_W'(MAX_DEPTH));
        for (k = 0; k < MAX_DEPTH; k++)
            send_beat(upward ? SAMPLE_LO + SAMPLE_W'($urandom_range(0, 7))
                             : SAMPLE_HI - SAMPLE_W'($urandom_range(0, 7)), $urandom);
        settle();
        write_reg(REG_MODE, PDATA_W'(MODE_WINDOW));
        write_reg(REG_WINDOW, PDATA_W'(1));
        send_beat(upward ? SAMPLE_HI : SAMPLE_LO, $urandom);
        settle();
        write_reg(REG_MODE, PDATA_W'(MODE_AVERAGE));
        for (k = 0; k < RAIL_BEATS; k++)
            send_beat(upward ? SAMPLE_HI - SAMPLE_W'($urandom_range(0, 3))
                             : SAMPLE_LO + SAMPLE_W'($urandom_range(0, 3)), $urandom);
        settle();
        write_reg(REG_DEPTH, PDATA_W'(1));
        for (k = 0; k < 3; k++)
            send_beat(upward ? SAMPLE_HI : SAMPLE_LO, $urandom);
    endtask

    task automatic run_block(input int blk);
        int                 k;
        int                 step_max;
        logic [PDATA_W-1:0] depth_val;
        logic [PDATA_W-1:0] win_val;
        logic [STAMP_W-1:0] t;
        settle();
        case (blk % 4)
            0: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct = 63;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct = 0;
                recv_stall_pct = 63;
            end
            default: begin
                send_idle_pct = 18;
                recv_stall_pct = 18;
            end
        endcase
        case ($urandom_range(9))
            0: depth_val = 0;
            1: depth_val = 127;
            2: depth_val = MAX_DEPTH;
            3: depth_val = $urandom_range(MAX_DEPTH + 1, 127);
            4: depth_val = 1;
            default: depth_val = $urandom_range(2, 8);
        endcase
        case ($urandom_range(7))
            0: win_val = 0;
            1: win_val = 1;
            2: win_val = 32'hFFFF_FFFF;
            3: win_val = 60000;
            4: win_val = $urandom;
            default: win_val = $urandom_range(2, 400);
        endcase
        case ($urandom_range(3))
            0: step_max = 0;
            1: step_max = 20;
            2: step_max = 200;
            default: step_max = 5000;
        endcase
        write_reg(REG_MODE, PDATA_W'(($urandom_range(2) != 0) ? MODE_WINDOW : MODE_AVERAGE));
        write_reg(REG_DEPTH, depth_val);
        write_reg(REG_WINDOW, win_val);
        if ($urandom_range(3) == 0) begin
            now_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        end
        if (blk == 0) begin
            hold_req <= 1'b1;
        end
        for (k = 0; k < BLOCK_BEATS; k++) begin
            case ($urandom_range(19))
                0: t = $urandom;
                1: t = now_ms - $urandom_range(1, 100);
                default: begin
                    now_ms = now_ms + $urandom_range(0, step_max);
                    t = now_ms;
                end
            endcase
            send_beat(pick_sample(), t);
        end
    endtask

    initial begin
        int blk;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: average mode, full depth
        send_beat(-16'sd5, 32'h0000_0000);
        send_beat(SAMPLE_HI, 32'hFFFF_FFFF);
        send_beat(SAMPLE_LO, 32'h0000_0001);
        send_beat(16'sd1, 32'h8000_0000);
        send_beat(-16'sd1, 32'h7FFF_FFFF);
        settle();
        write_reg(REG_DEPTH, PDATA_W'(0));
        send_beat(16'sd100, 32'd2);
        send_beat(-16'sd200, 32'd3);
        settle();
        write_reg(REG_DEPTH, PDATA_W'(127));
        send_beat(SAMPLE_LO, 32'd4);
        send_beat(SAMPLE_HI, 32'd5);
        settle();
        write_reg(REG_MODE, PDATA_W'(MODE_WINDOW));
        write_reg(REG_DEPTH, PDATA_W'(4));
        write_reg(REG_WINDOW, PDATA_W'(0));
        send_beat(16'sd300, 32'd10);
        send_beat(-16'sd300, 32'd11);
        settle();
        write_reg(REG_WINDOW, PDATA_W'(1));
        send_beat(16'sd7, 32'd20);
        settle();
        write_reg(REG_WINDOW, PDATA_W'(10));
        send_beat(16'sd8, 32'd25);
        send_beat(16'sd9, 32'd29);
        send_beat(16'sd10, 32'd15);
        settle();
        write_reg(REG_WINDOW, 32'hFFFF_FFFF);
        send_beat(16'sd11, 32'hFFFF_FFF0);
        send_beat(16'sd12, 32'h0000_0005);
        settle();
        write_reg(REG_MODE, PDATA_W'(MODE_AVERAGE));
        write_reg(REG_DEPTH, PDATA_W'(3));
        send_beat(16'sd20, 32'd0);
        send_beat(-16'sd40, 32'd0);

        for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            run_block(blk);
            if (blk == 5) begin
                drive_total_to_rail(1'b1);
            end
            if (blk == 11) begin
                drive_total_to_rail(1'b0);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("sliding_window_average_and_sum_core verification clean");
        end else begin
            $display("sliding_window_average_and_sum_core verification failed");
        end
        $finish;
    end

endmodule
